### sv/bsfw_pkg.sv
// Package for the binary semaphore block with FIFO wait queues.
// Holds the outcome codes and the fixed field widths; depends on nothing.
`default_nettype none

package bsfw_pkg;

    localparam int OUTCOME_W = 2;
    localparam int SEM_W     = 1;

    typedef logic [OUTCOME_W-1:0] outcome_t;

    localparam outcome_t OUT_ACQUIRED = 2'd0;
    localparam outcome_t OUT_QUEUED   = 2'd1;
    localparam outcome_t OUT_RELEASED = 2'd2;
    localparam outcome_t OUT_IGNORED  = 2'd3;

endpackage

`default_nettype wire

### sv/binary_semaphore_fifo_waiters.sv
// Top level: input register, request core and output register with handshakes.
// Depends on bsfw_pkg and bsfw_core.
//
// Channel   Direction  Payload
// s_axis    in         thread_id
// m_axis    out        outcome, sem_index, woke_valid, woke_thread, sem_taken, waiter_count
// cfg       in         thread_sem_map
//
// A request is taken into the input register, decided and written to the output
// register once the output has room: one request per cycle while m_axis is not stalled.
// The core decides each request in a single pass; flag and queue updates
// land on the same edge as the result. Reset frees both semaphores, empties the
// queues and sets the thread map to its default. An output stall holds the
// result and the waiting request, and the input stalls only when both are full.
`default_nettype none

module binary_semaphore_fifo_waiters #(
    parameter int NUM_SEMS    = 2,
    parameter int NUM_THREADS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [NUM_THREADS-1:0] cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: thread_id.
    input  wire logic [(($clog2(NUM_THREADS)+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // Fields from bit 0: outcome, sem_index, woke_valid, woke_thread, sem_taken,
    // waiter_count.
    output logic [((2*$clog2(NUM_THREADS)+5+7)/8)*8-1:0] m_tdata
);

    import bsfw_pkg::*;

    localparam int ID_W   = $clog2(NUM_THREADS);
    localparam int RES_W  = OUTCOME_W + SEM_W + 1 + ID_W + 1 + ID_W;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
    localparam logic [NUM_THREADS-1:0] MAP_RESET = NUM_THREADS'(12);

    logic [NUM_THREADS-1:0] map_reg;
    logic                   in_valid_reg;
    logic [ID_W-1:0]        tid_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   fire;
    logic                   take_in;

    outcome_t         res_outcome;
    logic [SEM_W-1:0] res_sem;
    logic             res_woke_valid;
    logic [ID_W-1:0]  res_woke_thread;
    logic             res_taken;
    logic [ID_W-1:0]  res_count;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign take_in  = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= MAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                map_reg <= cfg_wdata;
            end
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            tid_reg <= s_tdata[ID_W-1:0];
        end
        if (fire)
        begin
            out_data_reg <= OUT_W'({res_count, res_taken, res_woke_thread,
                                    res_woke_valid, res_sem, res_outcome});
        end
    end

    bsfw_core #(
        .NUM_SEMS   (NUM_SEMS),
        .NUM_THREADS(NUM_THREADS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .tid         (tid_reg),
        .sem_map     (map_reg),
        .outcome     (res_outcome),
        .sem_index   (res_sem),
        .woke_valid  (res_woke_valid),
        .woke_thread (res_woke_thread),
        .sem_taken   (res_taken),
        .waiter_count(res_count)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### sv/bsfw_wait_queue.sv
// Wait queue of one semaphore: a shift line of thread ids with a fill count.
// Stand-alone module; uses no package.
`default_nettype none

module bsfw_wait_queue #(
    parameter int NUM_THREADS = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic                           pop,
    input  wire logic [$clog2(NUM_THREADS)-1:0] push_id,
    output logic      [$clog2(NUM_THREADS)-1:0] head,
    output logic      [$clog2(NUM_THREADS)-1:0] count
);

    localparam int ID_W = $clog2(NUM_THREADS);

    logic [ID_W-1:0] slots_reg [NUM_THREADS];
    logic [ID_W-1:0] count_reg;
    logic [ID_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload slots need no reset; only slots below the count are ever read.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[count_reg] <= push_id;
        end
        else if (pop)
        begin
            for (int k = 0; k < NUM_THREADS - 1; k++)
            begin
                slots_reg[k] <= slots_reg[k+1];
            end
        end
    end

    assign head  = slots_reg[0];
    assign count = count_reg;

endmodule

`default_nettype wire

### sv/bsfw_core.sv
// Semaphore state and the single-pass decision for one toggle request.
// Depends on bsfw_pkg and instantiates bsfw_wait_queue per semaphore.
`default_nettype none

module bsfw_core #(
    parameter int NUM_SEMS    = 2,
    parameter int NUM_THREADS = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic [$clog2(NUM_THREADS)-1:0] tid,
    input  wire logic [NUM_THREADS-1:0]         sem_map,
    output bsfw_pkg::outcome_t                  outcome,
    output logic      [bsfw_pkg::SEM_W-1:0]     sem_index,
    output logic                                woke_valid,
    output logic      [$clog2(NUM_THREADS)-1:0] woke_thread,
    output logic                                sem_taken,
    output logic      [$clog2(NUM_THREADS)-1:0] waiter_count
);

    import bsfw_pkg::*;

    localparam int ID_W     = $clog2(NUM_THREADS);
    localparam int SEM_USED = (NUM_SEMS < 2) ? NUM_SEMS : 2;
    localparam logic [ID_W-1:0] QUEUE_CAP = ID_W'(NUM_THREADS - 1);

    logic [SEM_USED-1:0]    taken_reg;
    logic [SEM_USED-1:0]    taken_next;
    logic [NUM_THREADS-1:0] blocked_reg;
    logic [NUM_THREADS-1:0] blocked_next;
    logic [NUM_THREADS-1:0] holding_reg;
    logic [NUM_THREADS-1:0] holding_next;

    logic [ID_W-1:0]     q_head  [SEM_USED];
    logic [ID_W-1:0]     q_count [SEM_USED];
    logic [SEM_USED-1:0] q_push;
    logic [SEM_USED-1:0] q_pop;

    logic             tid_ok;
    logic             sem_ok;
    logic [SEM_W-1:0] sem;
    logic             cur_taken;
    logic [ID_W-1:0]  cur_count;
    logic [ID_W-1:0]  cur_head;
    logic             do_push;
    logic             do_pop;

    assign tid_ok = ({1'b0, tid} < (ID_W+1)'(NUM_THREADS));
    assign sem    = sem_map[tid];
    assign sem_ok = (NUM_SEMS > 1) || (sem == SEM_W'(0));

    always_comb
    begin
        cur_taken = 1'b0;
        cur_count = '0;
        cur_head  = '0;
        for (int g = 0; g < SEM_USED; g++)
        begin
            if (sem == SEM_W'(g))
            begin
                cur_taken = taken_reg[g];
                cur_count = q_count[g];
                cur_head  = q_head[g];
            end
        end
    end

    always_comb
    begin
        outcome      = OUT_IGNORED;
        sem_index    = '0;
        woke_valid   = 1'b0;
        woke_thread  = '0;
        sem_taken    = 1'b0;
        waiter_count = '0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        taken_next   = taken_reg;
        blocked_next = blocked_reg;
        holding_next = holding_reg;
        priority if (!tid_ok)
        begin
            outcome = OUT_IGNORED;
        end
        else if (!sem_ok)
        begin
            sem_index = sem;
        end
        else
        begin
            sem_index    = sem;
            sem_taken    = cur_taken;
            waiter_count = cur_count;
            priority if (blocked_reg[tid])
            begin
                outcome = OUT_IGNORED;
            end
            else if (!holding_reg[tid])
            begin
                priority if (!cur_taken)
                begin
                    outcome           = OUT_ACQUIRED;
                    sem_taken         = 1'b1;
                    holding_next[tid] = 1'b1;
                    for (int g = 0; g < SEM_USED; g++)
                    begin
                        if (sem == SEM_W'(g))
                        begin
                            taken_next[g] = 1'b1;
                        end
                    end
                end
                else if (cur_count >= QUEUE_CAP)
                begin
                    outcome = OUT_IGNORED;
                end
                else
                begin
                    outcome           = OUT_QUEUED;
                    do_push           = 1'b1;
                    waiter_count      = cur_count + 1'b1;
                    blocked_next[tid] = 1'b1;
                end
            end
            else
            begin
                outcome           = OUT_RELEASED;
                holding_next[tid] = 1'b0;
                if (cur_count == '0)
                begin
                    sem_taken = 1'b0;
                    for (int g = 0; g < SEM_USED; g++)
                    begin
                        if (sem == SEM_W'(g))
                        begin
                            taken_next[g] = 1'b0;
                        end
                    end
                end
                else
                begin
                    do_pop                 = 1'b1;
                    woke_valid             = 1'b1;
                    woke_thread            = cur_head;
                    sem_taken              = 1'b1;
                    waiter_count           = cur_count - 1'b1;
                    blocked_next[cur_head] = 1'b0;
                    holding_next[cur_head] = 1'b1;
                    for (int g = 0; g < SEM_USED; g++)
                    begin
                        if (sem == SEM_W'(g))
                        begin
                            taken_next[g] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg   <= '0;
            blocked_reg <= '0;
            holding_reg <= '0;
        end
        else if (fire)
        begin
            taken_reg   <= taken_next;
            blocked_reg <= blocked_next;
            holding_reg <= holding_next;
        end
    end

    for (genvar g = 0; g < SEM_USED; g++)
    begin : g_queue
        assign q_push[g] = fire && do_push && (sem == SEM_W'(g));
        assign q_pop[g]  = fire && do_pop && (sem == SEM_W'(g));

        bsfw_wait_queue #(
            .NUM_THREADS(NUM_THREADS)
        ) u_queue (
            .clk    (clk),
            .rst_n  (rst_n),
            .push   (q_push[g]),
            .pop    (q_pop[g]),
            .push_id(tid),
            .head   (q_head[g]),
            .count  (q_count[g])
        );
    end

    logic [ID_W+3:0] wait_total;

    always_comb
    begin
        wait_total = '0;
        for (int g = 0; g < SEM_USED; g++)
        begin
            wait_total = wait_total + (ID_W+4)'(q_count[g]);
        end
    end

    a_hold_block_disjoint: assert property (
        @(posedge clk) disable iff (!rst_n)
        (holding_reg & blocked_reg) == '0
    ) else $error("A thread is both holding and blocked.");

    a_blocked_matches_queues: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(blocked_reg) == int'(wait_total)
    ) else $error("Blocked threads do not match the queued waiters.");

    for (genvar g = 0; g < SEM_USED; g++)
    begin : g_chk
        a_waiters_imply_taken: assert property (
            @(posedge clk) disable iff (!rst_n)
            (q_count[g] != '0) |-> taken_reg[g]
        ) else $error("A semaphore with waiters is marked free.");
    end

endmodule

`default_nettype wire
